// ===== rtl/wtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wtm_pkg;

    // Fixed field widths
    localparam int RATE_W  = 32;
    localparam int BYTE_W  = 16;
    localparam int WIN_W   = 4;

    // Window register reset value
    localparam logic [WIN_W-1:0] WIN_RESET = 4'd3;

    // Input action codes
    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic update;
        logic scan;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/wtm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wtm_ctrl
    import wtm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // Sequence one item: update, scan, divide, hand off
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.update = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wtm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wtm_datapath
    import wtm_pkg::*;
#(
    parameter int MAX_WINDOW = 15
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cmd_t                               cmd,
    output status_t                                 st,
    input  wire logic                               cfg_we,
    input  wire logic [WIN_W-1:0]                   cfg_window,
    input  wire logic                               action,
    input  wire logic [BYTE_W-1:0]                  byte_count,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [RATE_W-1:0]                       rate,
    output logic [$clog2(MAX_WINDOW+2)-1:0]         present_buckets
);

    localparam int NB    = MAX_WINDOW + 1;
    localparam int AGE_W = $clog2(NB);
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);
    localparam int SUM_W = RATE_W + AGE_W;
    localparam int DC_W  = $clog2(SUM_W);
    localparam int CMP_W = (AGE_W > WIN_W) ? AGE_W : WIN_W;

    logic [WIN_W-1:0]  win_reg;
    logic [RATE_W-1:0] bytes_reg [NB];
    logic [RATE_W-1:0] bytes_next [NB];
    logic [NB-1:0]     pres_reg;
    logic [NB-1:0]     pres_next;

    logic [AGE_W-1:0]  age_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [AGE_W-1:0]  second_reg;
    logic [AGE_W-1:0]  oldest_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic [SUM_W-1:0]  quo_reg;
    logic [AGE_W-1:0]  rem_reg;
    logic [AGE_W-1:0]  dvs_reg;
    logic [DC_W-1:0]   dcnt_reg;

    logic              out_valid_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [CNT_W-1:0]  present_reg;

    logic [RATE_W:0]   rx_sum;
    logic              keep;
    logic [AGE_W:0]    trial;
    logic              trial_ge;
    logic [RATE_W-1:0] quo_sat;

    // Saturating add into the current-second bucket
    assign rx_sum = {1'b0, bytes_reg[0]} + (RATE_W+1)'(byte_count);

    // Bucket at the tap survives if present and within the window
    assign keep = pres_reg[0] && (CMP_W'(age_reg) <= CMP_W'(win_reg));

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    // Clamp quotient to the rate width
    assign quo_sat = (|quo_reg[SUM_W-1:RATE_W]) ? '1 : quo_reg[RATE_W-1:0];

    // Bucket line: update on accept, rotate through the tap while scanning
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            bytes_next[i] = bytes_reg[i];
        end
        pres_next = pres_reg;
        if (cmd.update)
        begin
            if (action == ACT_RX)
            begin
                bytes_next[0] = rx_sum[RATE_W] ? '1 : rx_sum[RATE_W-1:0];
                pres_next[0]  = 1'b1;
            end
            else
            begin
                for (int i = 1; i < NB; i++)
                begin
                    bytes_next[i] = bytes_reg[i-1];
                    pres_next[i]  = pres_reg[i-1];
                end
                bytes_next[0] = '0;
                pres_next[0]  = 1'b0;
            end
        end
        else if (cmd.scan)
        begin
            for (int i = 0; i < NB - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
                pres_next[i]  = pres_reg[i+1];
            end
            bytes_next[NB-1] = keep ? bytes_reg[0] : '0;
            pres_next[NB-1]  = keep;
        end
    end

    // Hold buckets and window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                bytes_reg[i] <= '0;
            end
            pres_reg <= '0;
            win_reg  <= WIN_RESET;
        end
        else
        begin
            for (int i = 0; i < NB; i++)
            begin
                bytes_reg[i] <= bytes_next[i];
            end
            pres_reg <= pres_next;
            if (cfg_we)
            begin
                win_reg <= cfg_window;
            end
        end
    end

    // Scan accumulators: count, second-newest, oldest, sum of older buckets
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            age_reg    <= '0;
            cnt_reg    <= '0;
            second_reg <= '0;
            oldest_reg <= '0;
            sum_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            age_reg <= age_reg + AGE_W'(1);
            if (keep)
            begin
                cnt_reg    <= cnt_reg + CNT_W'(1);
                oldest_reg <= age_reg;
                if (cnt_reg != '0)
                begin
                    sum_reg <= sum_reg + SUM_W'(bytes_reg[0]);
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    second_reg <= age_reg;
                end
            end
        end
    end

    // Divider: one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dvs_reg  <= oldest_reg - second_reg + AGE_W'(1);
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? AGE_W'(trial - {1'b0, dvs_reg}) : trial[AGE_W-1:0];
            dcnt_reg <= dcnt_reg + DC_W'(1);
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rate_reg    <= (cnt_reg >= CNT_W'(2)) ? quo_sat : '0;
            present_reg <= cnt_reg;
        end
    end

    assign st.scan_last = (age_reg == AGE_W'(NB - 1));
    assign st.div_last  = (dcnt_reg == DC_W'(SUM_W - 1));
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign rate            = rate_reg;
    assign present_buckets = present_reg;

endmodule

`default_nettype wire

// ===== rtl/windowed_throughput_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window byte throughput meter. Each input beat is either a receive
// event (action 0, byte_count added to the current-second bucket) or a
// one-second tick (action 1, ages every bucket). Each beat yields one result
// beat: the rate over present buckets except the newest, and the number of
// present buckets. An item passes from acceptance to result in these steps:
// update, rotate every bucket of the bucket line past the scan tap, load
// the divider, run the restoring divider over 32 + clog2(MAX_WINDOW+1)
// quotient bits, and load the output register. The next item is accepted
// the cycle after the result is loaded, and not before, so items do not
// overlap; if the previous result still waits in the output register when
// the divider finishes, the controller holds until it is taken.
// window_seconds may be written only while idle.

module windowed_throughput_meter
    import wtm_pkg::*;
#(
    parameter int MAX_WINDOW = 15
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [WIN_W-1:0]                   window_seconds,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               action,
    input  wire logic [BYTE_W-1:0]                  byte_count,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [RATE_W-1:0]                       rate,
    output logic [$clog2(MAX_WINDOW+2)-1:0]         present_buckets
);

    cmd_t    cmd;
    status_t st;

    // Window register takes a write at any time
    assign cfg_ready = 1'b1;

    wtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    wtm_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_valid),
        .cfg_window      (window_seconds),
        .action          (action),
        .byte_count      (byte_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rate            (rate),
        .present_buckets (present_buckets)
    );

endmodule

`default_nettype wire

// ===== verif/windowed_throughput_meter_tb.sv =====
`timescale 1ns / 1ps

module windowed_throughput_meter_tb;
    import wtm_pkg::*;

    localparam int METER_DEPTH = 15;
    localparam int CNT_W = $clog2(METER_DEPTH + 2);
    localparam int HALF_PERIOD = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic [CNT_W-1:0]  present;
    } reading_t;

    // Bucket-history model of the meter plus the queue of readings it predicts
    class meter_scoreboard;
        logic [RATE_W-1:0] bucket_total [METER_DEPTH+1];
        bit                bucket_live [METER_DEPTH+1];
        logic [WIN_W-1:0]  window;
        reading_t          pending [$];
        int                errors;
        int                checked;

        function new();
            for (int a = 0; a <= METER_DEPTH; a++)
            begin
                bucket_total[a] = '0;
                bucket_live[a] = 1'b0;
            end
            window = WIN_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_window(logic [WIN_W-1:0] w);
            window = w;
        endfunction

        // Apply one accepted beat and queue the reading it must produce
        function void note_item(logic act, logic [BYTE_W-1:0] cnt);
            logic [RATE_W:0] grown;
            int              keep;
            int              live;
            int              second_age;
            int              oldest_age;
            logic [63:0]     total;
            logic [63:0]     quotient;
            reading_t        r;

            if (act == ACT_RX)
            begin
                grown = {1'b0, bucket_total[0]} + (RATE_W+1)'(cnt);
                bucket_total[0] = grown[RATE_W] ? '1 : grown[RATE_W-1:0];
                bucket_live[0] = 1'b1;
            end
            else
            begin
                for (int a = METER_DEPTH; a > 0; a--)
                begin
                    bucket_total[a] = bucket_total[a-1];
                    bucket_live[a] = bucket_live[a-1];
                end
                bucket_total[0] = '0;
                bucket_live[0] = 1'b0;
            end

            // Drop buckets older than the window
            keep = (int'(window) > METER_DEPTH) ? METER_DEPTH : int'(window);
            for (int a = keep + 1; a <= METER_DEPTH; a++)
            begin
                bucket_total[a] = '0;
                bucket_live[a] = 1'b0;
            end

            // Sum every live bucket but the newest
            live = 0;
            second_age = 0;
            oldest_age = 0;
            total = '0;
            for (int a = 0; a <= METER_DEPTH; a++)
            begin
                if (bucket_live[a])
                begin
                    live++;
                    oldest_age = a;
                    if (live == 2)
                        second_age = a;
                    if (live >= 2)
                        total += bucket_total[a];
                end
            end

            r.rate = '0;
            if (live >= 2)
            begin
                quotient = total / (oldest_age - second_age + 1);
                r.rate = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[RATE_W-1:0];
            end
            r.present = live[CNT_W-1:0];
            pending.push_back(r);
        endfunction

        // Compare one result beat with the oldest queued reading
        function void check_result(logic [RATE_W-1:0] rate, logic [CNT_W-1:0] present);
            reading_t want;

            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected reading rate=%0d present=%0d",
                             $realtime, rate, present);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (rate !== want.rate || present !== want.present)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"%0t: reading mismatch: expected rate=%0d present=%0d,",
                              " got rate=%0d present=%0d"},
                             $realtime, want.rate, want.present, rate, present);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WIN_W-1:0]     window_seconds;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [BYTE_W-1:0]    byte_count;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [RATE_W-1:0]    rate;
    logic [CNT_W-1:0]     present_buckets;

    logic [15:0]          ready_pattern = 16'hFFFF;
    int                   pattern_pos = 0;
    int                   quiet_cycles = 0;
    int                   rx_beats = 0;
    int                   tick_beats = 0;
    int                   window_writes = 0;

    meter_scoreboard      sb = new();

    windowed_throughput_meter #(
        .MAX_WINDOW(METER_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .window_seconds(window_seconds),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .byte_count(byte_count),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .rate(rate),
        .present_buckets(present_buckets)
    );

    always #HALF_PERIOD clk = ~clk;

    // Stall the result channel on a repeating pattern
    always @(posedge clk)
    begin
        out_ready <= ready_pattern[pattern_pos];
        pattern_pos <= (pattern_pos + 1) % 16;
    end

    // Check result beats, record input beats, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(rate, present_buckets);
            if (in_valid && in_ready)
            begin
                sb.note_item(action, byte_count);
                if (action == ACT_TICK)
                    tick_beats++;
                else
                    rx_beats++;
            end
            if ((out_valid && out_ready) || (in_valid && in_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one beat and hold it until accepted
    task automatic send_item(logic act, logic [BYTE_W-1:0] cnt);
        in_valid <= 1'b1;
        action <= act;
        byte_count <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off the sender until every queued reading has arrived
    task automatic drain_results();
        idle_input(1);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] w);
        drain_results();
        cfg_valid <= 1'b1;
        window_seconds <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_window(w);
        window_writes++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_bytes();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return BYTE_W'($urandom_range(1, 255));
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Directed opening: empty, full and ignored counts, aging out, window extremes
    task automatic run_directed();
        send_item(ACT_RX, 16'h0000);
        send_item(ACT_TICK, 16'hFFFF);
        send_item(ACT_RX, 16'hFFFF);
        send_item(ACT_RX, 16'hFFFF);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_RX, 16'h0001);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_RX, 16'd100);
        repeat (4) send_item(ACT_TICK, 16'h0000);
        write_window(4'd0);
        send_item(ACT_RX, 16'd500);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_RX, 16'd7);
        send_item(ACT_RX, 16'hFFFF);
        write_window(4'd15);
        send_item(ACT_RX, 16'h8000);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_RX, 16'd3);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_RX, 16'h00FF);
        write_window(4'd1);
        send_item(ACT_RX, 16'd42);
        send_item(ACT_TICK, 16'h0000);
    endtask

    // Random phase: bursts of beats at one window, with sender gaps and drains
    task automatic run_phase(logic [WIN_W-1:0] w, int count);
        int   sent;
        int   burst;
        int   tick_pct;
        bit   no_gaps;
        logic [15:0] pat;
        logic act;

        write_window(w);
        tick_pct = $urandom_range(10, 60);
        no_gaps = ($urandom_range(0, 3) == 0);
        pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        if (pat == 16'h0000)
            pat = 16'h0001;
        ready_pattern <= pat;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                act = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_RX;
                send_item(act, pick_bytes());
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                drain_results();
            else if (!no_gaps)
                idle_input($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        logic [WIN_W-1:0] phase_window [10];

        phase_window = '{4'd15, 4'd2, 4'd0, 4'd7, 4'd15, 4'd1, 4'd9, 4'd4, 4'd12, 4'd15};
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_RX;
        byte_count = '0;
        cfg_valid = 1'b0;
        window_seconds = WIN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        foreach (phase_window[p])
            run_phase(phase_window[p], 170);

        // Wait out the last readings, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.errors += sb.pending.size();
            $display("%0d expected readings never arrived", sb.pending.size());
        end

        $display("Sent %0d receive beats and %0d ticks across %0d window writes;",
                 rx_beats, tick_beats, window_writes);
        $display("checked %0d readings, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
